[src/pafk_pkg.sv]
package pafk_pkg;

   localparam int MAX_LINKS    = 3;
   localparam int TRIG_STAGES  = 16;
   localparam int LINKS        = 3;
   localparam int ATAN_ENTRIES = 24;
   localparam int STAGES       = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
   localparam int LANE_LAT     = STAGES + 2;
   localparam int MERGE_LAT    = 2;
   localparam int TOTAL_LAT    = LANE_LAT + MERGE_LAT;
   localparam int DW           = 36;
   localparam int SW           = DW + 2;
   localparam int PW           = 19;
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   localparam logic [1:0] REG_LINK_COUNT = 2'd0;
   localparam logic [1:0] REG_LENGTH_0   = 2'd1;
   localparam logic [1:0] REG_LENGTH_1   = 2'd2;
   localparam logic [1:0] REG_LENGTH_2   = 2'd3;

   typedef logic signed [DW-1:0] coord_type;

   typedef struct packed {
      logic [1:0] sel;
      logic       bad;
   } side_type;

   function automatic logic [31:0] atan_lookup(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

[src/pafk_if.sv]
interface pafk_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] angle_a;
   logic [15:0] angle_b;
   logic [15:0] angle_c;
   logic [1:0]  joint_select;
   modport source(output valid, angle_a, angle_b, angle_c, joint_select, input ready);
   modport sink(input valid, angle_a, angle_b, angle_c, joint_select, output ready);
endinterface

interface pafk_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [18:0] pos_x;
   logic signed [18:0] pos_y;
   logic               bad_index;
   modport source(output valid, pos_x, pos_y, bad_index, input ready);
   modport sink(input valid, pos_x, pos_y, bad_index, output ready);
endinterface

[src/pafk_lane.sv]
module pafk_lane (
   input  logic                 clock,
   input  logic                 en,
   input  logic [15:0]          len,
   input  logic [15:0]          ang,
   output pafk_pkg::coord_type  x_out,
   output pafk_pkg::coord_type  y_out
);
   import pafk_pkg::*;

   logic [31:0] prod_ff;
   logic [31:0] zp_ff;
   logic [45:0] prod_in;
   coord_type   x_ff [0:STAGES];
   coord_type   y_ff [0:STAGES];
   logic [31:0] z_ff [0:STAGES];
   coord_type   xs;

   // length pre-scaled by the CORDIC gain, Q.28
   assign prod_in = {30'd0, len} * {16'd0, GAIN_Q30};

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in[45:14];
         zp_ff   <= {ang, 16'd0};
      end
   end

   assign xs = coord_type'({{(DW-32){1'b0}}, prod_ff});

   // fold second and third quadrant onto the first and fourth
   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0] <= '0;
         if (zp_ff[31] != zp_ff[30]) begin
            x_ff[0] <= -xs;
            z_ff[0] <= zp_ff + 32'h80000000;
         end else begin
            x_ff[0] <= xs;
            z_ff[0] <= zp_ff;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      coord_type dx;
      coord_type dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][31]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - atan_lookup(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + atan_lookup(5'(i));
            end
         end
      end
   end

   assign x_out = x_ff[STAGES];
   assign y_out = y_ff[STAGES];

endmodule

[src/pafk_merge.sv]
module pafk_merge (
   input  logic                 clock,
   input  logic                 en,
   input  pafk_pkg::coord_type  lane_x [pafk_pkg::LINKS],
   input  pafk_pkg::coord_type  lane_y [pafk_pkg::LINKS],
   input  pafk_pkg::side_type   side,
   output logic signed [18:0]   pos_x,
   output logic signed [18:0]   pos_y,
   output logic                 bad_index
);
   import pafk_pkg::*;

   localparam logic signed [SW-1:0] POS_MAX = SW'(262143);
   localparam logic signed [SW-1:0] POS_MIN = -SW'(262144);
   localparam logic signed [SW-1:0] HALF    = SW'(32768);

   logic signed [SW-1:0] sum_x_in, sum_y_in, sum_x_ff, sum_y_ff;
   logic signed [SW-1:0] rx, ry;
   logic                 bad_ff;
   logic signed [PW-1:0] px, py;

   // only links below the selected joint contribute
   always_comb begin
      sum_x_in = '0;
      sum_y_in = '0;
      for (int k = 0; k < LINKS; k++) begin
         if (k < int'(side.sel)) begin
            sum_x_in = sum_x_in + SW'(lane_x[k]);
            sum_y_in = sum_y_in + SW'(lane_y[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         bad_ff   <= side.bad;
      end
   end

   assign rx = (sum_x_ff + HALF) >>> 16;
   assign ry = (sum_y_ff + HALF) >>> 16;

   always_comb begin
      if (rx > POS_MAX)      px = POS_MAX[PW-1:0];
      else if (rx < POS_MIN) px = POS_MIN[PW-1:0];
      else                   px = rx[PW-1:0];
      if (ry > POS_MAX)      py = POS_MAX[PW-1:0];
      else if (ry < POS_MIN) py = POS_MIN[PW-1:0];
      else                   py = ry[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x     <= bad_ff ? '0 : px;
         pos_y     <= bad_ff ? '0 : py;
         bad_index <= bad_ff;
      end
   end

endmodule

[src/planar_arm_forward_kinematics.sv]
// Pipeline from accepted word to result: multiply, fold, 16 CORDIC
// stages, lane sum, round and saturate.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset (synchronous): pipeline empty, link_count 2, all link lengths 1.0.
module planar_arm_forward_kinematics (
   input  logic        clock,
   input  logic        reset,
   pafk_req_if.sink    req,
   pafk_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pafk_pkg::*;

   logic [1:0]  link_count_ff;
   logic [15:0] len_ff [LINKS];
   logic        vld_ff [0:TOTAL_LAT-1];
   side_type    side_ff [0:LANE_LAT-1];
   side_type    side_in;
   logic        en;
   logic [1:0]  used;
   logic [15:0] cum [LINKS];
   coord_type   lane_x [LINKS];
   coord_type   lane_y [LINKS];

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_count_ff <= 2'd2;
         for (int k = 0; k < LINKS; k++) len_ff[k] <= 16'd4096;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            REG_LINK_COUNT: link_count_ff <= csr_pwdata[1:0];
            REG_LENGTH_0:   len_ff[0]     <= csr_pwdata[15:0];
            REG_LENGTH_1:   len_ff[1]     <= csr_pwdata[15:0];
            REG_LENGTH_2:   len_ff[2]     <= csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_LINK_COUNT: csr_prdata = {30'd0, link_count_ff};
         REG_LENGTH_0:   csr_prdata = {16'd0, len_ff[0]};
         REG_LENGTH_1:   csr_prdata = {16'd0, len_ff[1]};
         REG_LENGTH_2:   csr_prdata = {16'd0, len_ff[2]};
      endcase
   end

   assign en        = !vld_ff[TOTAL_LAT-1] || rsp.ready;
   assign req.ready = en;

   always_comb begin
      used = link_count_ff;
      if (int'(used) > MAX_LINKS) used = 2'(MAX_LINKS);
      if (int'(used) > LINKS)     used = 2'(LINKS);
   end

   assign side_in.sel = req.joint_select;
   assign side_in.bad = req.joint_select > used;

   // cumulative angles wrap modulo one turn
   assign cum[0] = req.angle_a;
   assign cum[1] = req.angle_a + req.angle_b;
   assign cum[2] = req.angle_a + req.angle_b + req.angle_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i < TOTAL_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LANE_LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   for (genvar k = 0; k < LINKS; k++) begin : g_lane
      pafk_lane u_lane (
         .clock (clock),
         .en    (en),
         .len   (len_ff[k]),
         .ang   (cum[k]),
         .x_out (lane_x[k]),
         .y_out (lane_y[k])
      );
   end

   pafk_merge u_merge (
      .clock     (clock),
      .en        (en),
      .lane_x    (lane_x),
      .lane_y    (lane_y),
      .side      (side_ff[LANE_LAT-1]),
      .pos_x     (rsp.pos_x),
      .pos_y     (rsp.pos_y),
      .bad_index (rsp.bad_index)
   );

   assign rsp.valid = vld_ff[TOTAL_LAT-1];

endmodule

[dv/planar_arm_forward_kinematics_tb.sv]
`timescale 1ns / 1ps

module planar_arm_forward_kinematics_tb;
   import pafk_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   pafk_req_if req ();
   pafk_rsp_if rsp ();

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   planar_arm_forward_kinematics dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   typedef struct packed {
      logic signed [18:0] x;
      logic signed [18:0] y;
      logic               bad;
   } pose_type;

   typedef struct {
      logic [15:0] a, b, c;
      logic [1:0]  sel;
      bit          known;
      pose_type    want;
   } row_type;

   localparam longint ATAN_T [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

   logic [1:0]  arm_links;
   logic [15:0] arm_len [3];

   pose_type pending_poses[$];
   int     errors = 0;
   int     words_in = 0, words_out = 0, bad_seen = 0;
   int     send_idle = 0, recv_stall = 0;

   // floor division by 2^s
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void rotate(input logic [15:0] len, input logic [15:0] ang,
                                  output longint rx, output longint ry);
      longint x, y, dx, dy;
      logic [31:0] z;
      x = (longint'(len) * 64'd652032874) >>> 14;
      y = 0;
      z = {ang, 16'h0};
      if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
         x = -x;
         z = z + 32'h80000000;
      end
      for (int i = 0; i < TRIG_STAGES && i < 24; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (!z[31]) begin
            x -= dx; y += dy; z = z - 32'(ATAN_T[i]);
         end else begin
            x += dx; y -= dy; z = z + 32'(ATAN_T[i]);
         end
      end
      rx = x;
      ry = y;
   endfunction

   function automatic logic signed [18:0] round_sat(longint v);
      longint r;
      r = fshift(v + 64'sd32768, 16);
      if (r > 262143) r = 262143;
      if (r < -262144) r = -262144;
      return 19'(r);
   endfunction

   function automatic pose_type joint_position(logic [15:0] a, logic [15:0] b,
                                               logic [15:0] c, logic [1:0] sel);
      pose_type p;
      int used;
      logic [15:0] angs [3];
      logic [15:0] cum;
      longint sx, sy, rx, ry;
      used = (arm_links > MAX_LINKS) ? MAX_LINKS : arm_links;
      p = '0;
      if (sel > used) begin
         p.bad = 1'b1;
         return p;
      end
      angs = '{a, b, c};
      cum = 0; sx = 0; sy = 0;
      for (int k = 0; k < sel; k++) begin
         cum = cum + angs[k];
         rotate(arm_len[k], cum, rx, ry);
         sx += rx; sy += ry;
      end
      p.x = round_sat(sx);
      p.y = round_sat(sy);
      return p;
   endfunction

   task automatic report(string what, pose_type got, pose_type want);
      errors++;
      $display("MISMATCH %s: got x=%0d y=%0d bad=%0b, want x=%0d y=%0d bad=%0b",
               what, got.x, got.y, got.bad, want.x, want.y, want.bad);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_LINK_COUNT: arm_links = val[1:0];
         REG_LENGTH_0:   arm_len[0] = val[15:0];
         REG_LENGTH_1:   arm_len[1] = val[15:0];
         default:        arm_len[2] = val[15:0];
      endcase
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (TOTAL_LAT + 4) @(posedge clock);
   endtask

   // one word; idle_pct is the chance of a gap cycle before it
   task automatic send_word(row_type r, int idle_pct);
      pose_type want;
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         send_idle++;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.angle_a <= r.a; req.angle_b <= r.b; req.angle_c <= r.c;
      req.joint_select <= r.sel;
      want = r.known ? r.want : joint_position(r.a, r.b, r.c, r.sel);
      pending_poses.insert(pending_poses.size(), want);
      words_in++;
      do @(posedge clock); while (!req.ready);
   endtask

   int stall_pct = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            pose_type got, want;
            got = '{rsp.pos_x, rsp.pos_y, rsp.bad_index};
            words_out++;
            if (got.bad) bad_seen++;
            if (pending_poses.size() == 0) begin
               report("unexpected word", got, got);
            end else begin
               want = pending_poses.pop_front();
               if (got.x !== want.x) report("pos_x", got, want);
               if (got.y !== want.y) report("pos_y", got, want);
               if (got.bad !== want.bad) report("bad_index", got, want);
            end
         end
         if (!rsp.ready) recv_stall++;
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic row_type rnd_row();
      row_type r;
      r.a = 16'($urandom); r.b = 16'($urandom); r.c = 16'($urandom);
      r.sel = 2'($urandom);
      r.known = 0;
      r.want = '0;
      return r;
   endfunction

   row_type directed [$];
   int   send_pct;

   initial begin
      arm_links = 2'd2;
      arm_len = '{16'd4096, 16'd4096, 16'd4096};
      req.valid = 1'b0;
      req.angle_a = '0; req.angle_b = '0; req.angle_c = '0;
      req.joint_select = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: two unit links
      directed = '{
         '{16'h0000, 16'h0000, 16'h0000, 2'd0, 1, '{19'sd0, 19'sd0, 1'b0}},
         '{16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0, 1, '{19'sd0, 19'sd0, 1'b0}},
         '{16'h1234, 16'h0000, 16'h0000, 2'd3, 1, '{19'sd0, 19'sd0, 1'b1}},
         '{16'h0000, 16'h0000, 16'h0000, 2'd1, 0, '0},
         '{16'h4000, 16'h0000, 16'h0000, 2'd1, 0, '0},
         '{16'h8000, 16'h0000, 16'h0000, 2'd1, 0, '0},
         '{16'hC000, 16'h0000, 16'h0000, 2'd1, 0, '0},
         '{16'h0000, 16'h0000, 16'h0000, 2'd2, 0, '0},
         '{16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd2, 0, '0},
         '{16'h8000, 16'h8000, 16'h0000, 2'd2, 0, '0},
         '{16'h2000, 16'h6000, 16'h0000, 2'd2, 0, '0}};
      foreach (directed[i]) send_word(directed[i], 0);
      drain();

      // extremes: longest links, three in use
      csr_write(REG_LINK_COUNT, 32'd3);
      csr_write(REG_LENGTH_0, 32'hFFFF);
      csr_write(REG_LENGTH_1, 32'hFFFF);
      csr_write(REG_LENGTH_2, 32'hFFFF);
      directed = '{
         '{16'h0000, 16'h0000, 16'h0000, 2'd3, 0, '0},
         '{16'h8000, 16'h0000, 16'h0000, 2'd3, 0, '0},
         '{16'h4000, 16'h0000, 16'h0000, 2'd3, 0, '0},
         '{16'hC000, 16'h0000, 16'h0000, 2'd3, 0, '0},
         '{16'h5555, 16'hAAAA, 16'h5555, 2'd3, 0, '0}};
      foreach (directed[i]) send_word(directed[i], 0);
      drain();

      // zero count: only the base is valid
      csr_write(REG_LINK_COUNT, 32'd0);
      csr_write(REG_LENGTH_0, 32'd0);
      directed = '{
         '{16'h0000, 16'h0000, 16'h0000, 2'd0, 1, '{19'sd0, 19'sd0, 1'b0}},
         '{16'h0000, 16'h0000, 16'h0000, 2'd1, 1, '{19'sd0, 19'sd0, 1'b1}},
         '{16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd2, 1, '{19'sd0, 19'sd0, 1'b1}}};
      foreach (directed[i]) send_word(directed[i], 0);
      drain();

      // random phases, each with fresh settings and idling
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_LINK_COUNT, (ph < 4) ? (ph % 4) : $urandom_range(1, 3));
         csr_write(REG_LENGTH_0, (ph == 5) ? 32'hFFFF : $urandom);
         csr_write(REG_LENGTH_1, (ph == 6) ? 32'h0 : $urandom);
         csr_write(REG_LENGTH_2, $urandom);
         case (ph % 4)
            0: begin send_pct = 0;  stall_pct = 0;  end
            1: begin send_pct = 55; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 55; end
            default: begin send_pct = 28; stall_pct = 28; end
         endcase
         for (int n = 0; n < 170; n++) begin
            send_word(rnd_row(), send_pct);
            // hold off until the pipe is empty once mid-phase
            if (n == 85) begin
               req.valid <= 1'b0;
               while (pending_poses.size() != 0) @(posedge clock);
            end
         end
         stall_pct = (ph % 4 == 2) ? 55 : stall_pct;
         drain();
         stall_pct = 0;
      end

      fork
         begin
            int guard = 0;
            while (pending_poses.size() != 0 && guard < 100000) begin
               @(posedge clock);
               guard++;
            end
         end
      join
      repeat (TOTAL_LAT + 4) @(posedge clock);
      $display("Covered %0d words in, %0d out (%0d bad index), all link counts 0..3,",
               words_in, words_out, bad_seen);
      $display("length extremes, %0d sender gaps and %0d receiver stalls.",
               send_idle, recv_stall);
      if (errors == 0 && pending_poses.size() == 0) begin
         $display("planar_arm_forward_kinematics test passed");
      end else begin
         $display("planar_arm_forward_kinematics test failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("planar_arm_forward_kinematics test failed");
      $finish;
   end

endmodule
